// File: hdl/assert_macros.svh
// Assertion macros shared by the segment and box overlap design.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold in the same cycle.
`define SBO_ASSERT(lbl, ck, rn, prop) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (prop)) else $error("assertion failed");

// Implication checked in the cycle after the trigger.
`define SBO_ASSERT_NEXT(lbl, ck, rn, pre, post) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (pre) |=> (post)) else $error("assertion failed");

`endif

// File: hdl/sbo_pkg.sv
// Package with shared constants and types of the segment and box overlap design.
package sbo_pkg;

  localparam int COORD_WIDTH_DEF = 32;
  localparam int NUM_FIELDS      = 12;
  localparam int F_LO            = 0;
  localparam int F_HI            = 3;
  localparam int F_ST            = 6;
  localparam int F_EN            = 9;

  typedef struct packed {
    logic valid;
    logic dead;
  } ctl_t;

endpackage

// File: hdl/sbo_if.sv
// Channel interfaces for test beats and result beats.
interface sbo_in_if #(parameter int CW = sbo_pkg::COORD_WIDTH_DEF);
  logic valid;
  logic ready;
  logic signed [CW-1:0] box_min_x;
  logic signed [CW-1:0] box_min_y;
  logic signed [CW-1:0] box_min_z;
  logic signed [CW-1:0] box_max_x;
  logic signed [CW-1:0] box_max_y;
  logic signed [CW-1:0] box_max_z;
  logic signed [CW-1:0] start_x;
  logic signed [CW-1:0] start_y;
  logic signed [CW-1:0] start_z;
  logic signed [CW-1:0] end_x;
  logic signed [CW-1:0] end_y;
  logic signed [CW-1:0] end_z;

  modport source (output valid, box_min_x, box_min_y, box_min_z, box_max_x, box_max_y,
                  box_max_z, start_x, start_y, start_z, end_x, end_y, end_z, input ready);
  modport sink (input valid, box_min_x, box_min_y, box_min_z, box_max_x, box_max_y,
                box_max_z, start_x, start_y, start_z, end_x, end_y, end_z, output ready);
endinterface

interface sbo_out_if;
  logic valid;
  logic ready;
  logic hit;

  modport source (output valid, hit, input ready);
  modport sink (input valid, hit, output ready);
endinterface

// File: hdl/sbo_reject.sv
// One pipeline stage that applies the slab reject test on one axis.
module sbo_reject #(
  parameter int CW   = sbo_pkg::COORD_WIDTH_DEF,
  parameter int AXIS = 0
) (
  input  logic                                      clk,
  input  logic                                      rst_n,
  input  logic                                      adv,
  input  sbo_pkg::ctl_t                             ctl_i,
  input  logic [sbo_pkg::NUM_FIELDS-1:0][CW-1:0]    crd_i,
  output sbo_pkg::ctl_t                             ctl_o,
  output logic [sbo_pkg::NUM_FIELDS-1:0][CW-1:0]    crd_o
);

  sbo_pkg::ctl_t                          ctl_r;
  sbo_pkg::ctl_t                          ctl_nxt;
  logic [sbo_pkg::NUM_FIELDS-1:0][CW-1:0] crd_r;
  logic signed [CW-1:0]                   a, b, lo, hi;
  logic                                   rej;

  always_comb begin
    a   = $signed(crd_i[sbo_pkg::F_ST + AXIS]);
    b   = $signed(crd_i[sbo_pkg::F_EN + AXIS]);
    lo  = $signed(crd_i[sbo_pkg::F_LO + AXIS]);
    hi  = $signed(crd_i[sbo_pkg::F_HI + AXIS]);
    rej = ((a <= lo) && (b <= lo)) || ((a >= hi) && (b >= hi));
    ctl_nxt.valid = ctl_i.valid;
    ctl_nxt.dead  = ctl_i.dead | rej;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else if (adv) begin
      ctl_r <= ctl_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      crd_r <= crd_i;
    end
  end

  assign ctl_o = ctl_r;
  assign crd_o = crd_r;

endmodule

// File: hdl/sbo_clip.sv
// Pipelined clip of one endpoint onto one bounding plane, with a bit-per-stage divider.
`include "assert_macros.svh"

module sbo_clip #(
  parameter int CW      = sbo_pkg::COORD_WIDTH_DEF,
  parameter int AXIS    = 0,
  parameter int DST     = 0,
  parameter int HIPLANE = 0
) (
  input  logic                                      clk,
  input  logic                                      rst_n,
  input  logic                                      adv,
  input  sbo_pkg::ctl_t                             ctl_i,
  input  logic [sbo_pkg::NUM_FIELDS-1:0][CW-1:0]    crd_i,
  output sbo_pkg::ctl_t                             ctl_o,
  output logic [sbo_pkg::NUM_FIELDS-1:0][CW-1:0]    crd_o
);

  localparam int MW    = CW + 1;
  localparam int J0    = (AXIS + 1) % 3;
  localparam int J1    = (AXIS + 2) % 3;
  localparam int DBASE = (DST != 0) ? sbo_pkg::F_EN : sbo_pkg::F_ST;

  typedef struct packed {
    logic [sbo_pkg::NUM_FIELDS-1:0][CW-1:0] crd;
    logic                                   req;
    logic                                   zden;
    logic [CW-1:0]                          plane;
    logic [MW-1:0]                          mden;
    logic [1:0]                             neg;
  } carry_t;

  function automatic logic [2*MW-1:0] div_step(input logic [2*MW-1:0] w,
                                               input logic [MW-1:0]   d);
    logic [MW:0] r;
    logic [MW:0] diff;
    r    = w[2*MW-1:MW-1];
    diff = r - {1'b0, d};
    if (r >= {1'b0, d}) begin
      div_step = {diff[MW-1:0], w[MW-2:0], 1'b1};
    end else begin
      div_step = {r[MW-1:0], w[MW-2:0], 1'b0};
    end
  endfunction

  function automatic logic [MW-1:0] mag(input logic signed [MW-1:0] x);
    mag = x[MW-1] ? MW'(-x) : x;
  endfunction

  // Setup stage.
  logic signed [CW-1:0]    a, b, p, cur;
  logic signed [MW-1:0]    den, num;
  logic signed [MW-1:0]    dj [2];
  carry_t                  c_p_nxt, c_p_r;
  sbo_pkg::ctl_t           ctl_p_r;
  logic [MW-1:0]           mnum_p_r;
  logic [1:0][MW-1:0]      mdj_p_r;

  always_comb begin
    a     = $signed(crd_i[sbo_pkg::F_ST + AXIS]);
    b     = $signed(crd_i[sbo_pkg::F_EN + AXIS]);
    p     = (HIPLANE != 0) ? $signed(crd_i[sbo_pkg::F_HI + AXIS])
                           : $signed(crd_i[sbo_pkg::F_LO + AXIS]);
    cur   = (DST != 0) ? b : a;
    den   = $signed({b[CW-1], b}) - $signed({a[CW-1], a});
    num   = $signed({p[CW-1], p}) - $signed({a[CW-1], a});
    dj[0] = $signed({crd_i[sbo_pkg::F_EN + J0][CW-1], crd_i[sbo_pkg::F_EN + J0]})
          - $signed({crd_i[sbo_pkg::F_ST + J0][CW-1], crd_i[sbo_pkg::F_ST + J0]});
    dj[1] = $signed({crd_i[sbo_pkg::F_EN + J1][CW-1], crd_i[sbo_pkg::F_EN + J1]})
          - $signed({crd_i[sbo_pkg::F_ST + J1][CW-1], crd_i[sbo_pkg::F_ST + J1]});
    c_p_nxt.crd   = crd_i;
    c_p_nxt.req   = ctl_i.valid && !ctl_i.dead && ((HIPLANE != 0) ? (cur > p) : (cur < p));
    c_p_nxt.zden  = (den == '0);
    c_p_nxt.plane = p;
    c_p_nxt.mden  = mag(den);
    c_p_nxt.neg   = {dj[1][MW-1] ^ num[MW-1] ^ den[MW-1], dj[0][MW-1] ^ num[MW-1] ^ den[MW-1]};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_p_r <= '0;
    end else if (adv) begin
      ctl_p_r <= ctl_i;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      c_p_r      <= c_p_nxt;
      mnum_p_r   <= mag(num);
      mdj_p_r[0] <= mag(dj[0]);
      mdj_p_r[1] <= mag(dj[1]);
    end
  end

  // Multiply stage.
  carry_t                  c_m_r;
  sbo_pkg::ctl_t           ctl_m_r;
  logic [1:0][2*MW-1:0]    prod_m_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_m_r <= '0;
    end else if (adv) begin
      ctl_m_r <= ctl_p_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      c_m_r       <= c_p_r;
      prod_m_r[0] <= mdj_p_r[0] * mnum_p_r;
      prod_m_r[1] <= mdj_p_r[1] * mnum_p_r;
    end
  end

  // Divide stages: overflow check, then one quotient bit per stage.
  carry_t                  c_d_r   [0:MW];
  sbo_pkg::ctl_t           ctl_d_r [0:MW];
  logic [1:0]              ov_d_r  [0:MW];
  logic [1:0][2*MW-1:0]    w_d_r   [0:MW];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_d_r[0] <= '0;
    end else if (adv) begin
      ctl_d_r[0] <= ctl_m_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      c_d_r[0]     <= c_m_r;
      ov_d_r[0][0] <= (prod_m_r[0][2*MW-1:MW] >= c_m_r.mden);
      ov_d_r[0][1] <= (prod_m_r[1][2*MW-1:MW] >= c_m_r.mden);
      w_d_r[0]     <= prod_m_r;
    end
  end

  for (genvar t = 1; t <= MW; t++) begin : g_div
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        ctl_d_r[t] <= '0;
      end else if (adv) begin
        ctl_d_r[t] <= ctl_d_r[t-1];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        c_d_r[t]    <= c_d_r[t-1];
        ov_d_r[t]   <= ov_d_r[t-1];
        w_d_r[t][0] <= div_step(w_d_r[t-1][0], c_d_r[t-1].mden);
        w_d_r[t][1] <= div_step(w_d_r[t-1][1], c_d_r[t-1].mden);
      end
    end
  end

  // Interpolate, saturate and write back.
  localparam logic [CW-1:0] MAXC = {1'b0, {(CW-1){1'b1}}};
  localparam logic [CW-1:0] MINC = {1'b1, {(CW-1){1'b0}}};

  logic [CW-1:0]                          res_w [2];
  logic [sbo_pkg::NUM_FIELDS-1:0][CW-1:0] crd_nxt, crd_r;
  sbo_pkg::ctl_t                          ctl_r;

  for (genvar k = 0; k < 2; k++) begin : g_res
    localparam int JK = (AXIS + 1 + k) % 3;
    logic signed [CW+2:0] ajx, qx, sum;
    logic                 fits;
    always_comb begin
      ajx  = {{3{c_d_r[MW].crd[sbo_pkg::F_ST + JK][CW-1]}}, c_d_r[MW].crd[sbo_pkg::F_ST + JK]};
      qx   = {2'b00, w_d_r[MW][k][MW-1:0]};
      sum  = c_d_r[MW].neg[k] ? (ajx - qx) : (ajx + qx);
      fits = (sum[CW+2:CW-1] == '0) || (sum[CW+2:CW-1] == '1);
      if (ov_d_r[MW][k]) begin
        res_w[k] = c_d_r[MW].neg[k] ? MINC : MAXC;
      end else if (fits) begin
        res_w[k] = sum[CW-1:0];
      end else begin
        res_w[k] = sum[CW+2] ? MINC : MAXC;
      end
    end
  end

  always_comb begin
    crd_nxt = c_d_r[MW].crd;
    if (c_d_r[MW].req) begin
      crd_nxt[DBASE + AXIS] = c_d_r[MW].plane;
      if (!c_d_r[MW].zden) begin
        crd_nxt[DBASE + J0] = res_w[0];
        crd_nxt[DBASE + J1] = res_w[1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else if (adv) begin
      ctl_r <= ctl_d_r[MW];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      crd_r <= crd_nxt;
    end
  end

  assign ctl_o = ctl_r;
  assign crd_o = crd_r;

  `SBO_ASSERT(a_req_live, clk, rst_n, !c_p_r.req || (ctl_p_r.valid && !ctl_p_r.dead))
  `SBO_ASSERT_NEXT(a_stall_hold, clk, rst_n, !adv, $stable(ctl_r) && $stable(crd_r))
  `SBO_ASSERT(a_rem_small, clk, rst_n, !(ctl_d_r[MW].valid && c_d_r[MW].req && !ov_d_r[MW][0]) || (w_d_r[MW][0][2*MW-1:MW] < c_d_r[MW].mden))

endmodule

// File: hdl/segment_box_overlap_clip.sv
// Top level of the pipelined segment and axis-aligned box overlap test.
//
//   Channel   Direction   Beat contents
//   in_ch     sink        box min and max corners, segment start and end
//   out_ch    source      hit flag
//
// A new beat is taken every cycle unless the pipe stalls; each beat passes through the
// pipe: six reject stages plus twelve clip units of COORD_WIDTH+5 stages each,
// set by the divider that produces one quotient bit per stage.
// Reset clears every valid bit; data registers are not reset.
// When a result beat is held back, the whole pipe stalls together and in_ch.ready drops.
module segment_box_overlap_clip #(
  parameter int COORD_WIDTH = sbo_pkg::COORD_WIDTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  sbo_in_if.sink    in_ch,
  sbo_out_if.source out_ch
);

  localparam int NU = 18;

  logic                                            adv;
  sbo_pkg::ctl_t                                   ctl_c [0:NU];
  logic [sbo_pkg::NUM_FIELDS-1:0][COORD_WIDTH-1:0] crd_c [0:NU];

  assign adv          = !out_ch.valid || out_ch.ready;
  assign in_ch.ready  = adv;
  assign ctl_c[0].valid = in_ch.valid;
  assign ctl_c[0].dead  = 1'b0;
  assign crd_c[0] = {in_ch.end_z, in_ch.end_y, in_ch.end_x,
                     in_ch.start_z, in_ch.start_y, in_ch.start_x,
                     in_ch.box_max_z, in_ch.box_max_y, in_ch.box_max_x,
                     in_ch.box_min_z, in_ch.box_min_y, in_ch.box_min_x};

  for (genvar ax = 0; ax < 3; ax++) begin : g_axis
    sbo_reject #(.CW(COORD_WIDTH), .AXIS(ax)) u_rej (
      .clk(clk), .rst_n(rst_n), .adv(adv),
      .ctl_i(ctl_c[ax*5]), .crd_i(crd_c[ax*5]),
      .ctl_o(ctl_c[ax*5+1]), .crd_o(crd_c[ax*5+1])
    );
    for (genvar k = 0; k < 4; k++) begin : g_clip
      sbo_clip #(.CW(COORD_WIDTH), .AXIS(ax), .DST(k / 2), .HIPLANE(k % 2)) u_clip (
        .clk(clk), .rst_n(rst_n), .adv(adv),
        .ctl_i(ctl_c[ax*5+1+k]), .crd_i(crd_c[ax*5+1+k]),
        .ctl_o(ctl_c[ax*5+2+k]), .crd_o(crd_c[ax*5+2+k])
      );
    end
  end

  for (genvar ax = 0; ax < 3; ax++) begin : g_final
    sbo_reject #(.CW(COORD_WIDTH), .AXIS(ax)) u_rej (
      .clk(clk), .rst_n(rst_n), .adv(adv),
      .ctl_i(ctl_c[15+ax]), .crd_i(crd_c[15+ax]),
      .ctl_o(ctl_c[16+ax]), .crd_o(crd_c[16+ax])
    );
  end

  assign out_ch.valid = ctl_c[NU].valid;
  assign out_ch.hit   = !ctl_c[NU].dead;

endmodule
